// File: rtl/parc_pkg.sv
// ----------------------------------------------------------------------------
// parc_pkg
// Shared codes and types for the page allocator with reference counts.
// ----------------------------------------------------------------------------
package parc_pkg;

	localparam int unsigned APB_AW = 5;
	localparam int unsigned APB_DW = 64;

	localparam logic [1:0] REG_MEM_BASE     = 2'd0;
	localparam logic [1:0] REG_MEM_TOP      = 2'd1;
	localparam logic [1:0] REG_RESERVED_END = 2'd2;

	localparam logic [2:0] FUNC_ALLOC  = 3'd0;
	localparam logic [2:0] FUNC_FREE   = 3'd1;
	localparam logic [2:0] FUNC_INCREF = 3'd2;
	localparam logic [2:0] FUNC_DECREF = 3'd3;
	localparam logic [2:0] FUNC_GETREF = 3'd4;

	localparam logic [2:0] STATUS_OK       = 3'd0;
	localparam logic [2:0] STATUS_NO_FREE  = 3'd1;
	localparam logic [2:0] STATUS_BAD_FREE = 3'd2;
	localparam logic [2:0] STATUS_STILL_REF = 3'd3;
	localparam logic [2:0] STATUS_OVERFLOW = 3'd4;

	localparam logic [39:0] MEM_BASE_RST     = 40'h00_8000_0000;
	localparam logic [39:0] MEM_TOP_RST      = 40'h00_8080_0000;
	localparam logic [39:0] RESERVED_END_RST = 40'h00_8020_0000;

	localparam logic [7:0] REF_MAX = 8'd255;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

endpackage

// File: rtl/parc_if.sv
// ----------------------------------------------------------------------------
// parc_req_if / parc_rsp_if
// Valid/ready channels carrying allocator requests and responses.
// ----------------------------------------------------------------------------
interface parc_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic [39:0] page_addr;

	modport source (output valid, output func, output page_addr, input ready);
	modport sink   (input valid, input func, input page_addr, output ready);
endinterface

interface parc_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [39:0] alloc_addr;
	logic [7:0]  ref_value;
	logic [11:0] free_pages;
	logic [23:0] free_bytes;

	modport source (output valid, output status, output alloc_addr, output ref_value,
		output free_pages, output free_bytes, input ready);
	modport sink   (input valid, input status, input alloc_addr, input ref_value,
		input free_pages, input free_bytes, output ready);
endinterface

// File: rtl/page_allocator_with_refcount_unit.sv
// ----------------------------------------------------------------------------
// page_allocator_with_refcount_unit
// Free page stack allocator with an 8-bit reference count per page.
// ----------------------------------------------------------------------------
// channel   dir   handshake      payload
// req       in    valid/ready    func, page_addr
// rsp       out   valid/ready    status, alloc_addr, ref_value, free_pages, free_bytes
// apb       in    psel/penable   paddr, pwdata, prdata (pready tied high)
//
// Each operation has a transfer cycle that reads the count and stack memories into
// registers and an ST_EXEC state that modifies and writes them back.
// req.ready is low in ST_EXEC, and while the count memory is cleared after reset.
// A response waits in its own register; the write-back cycle holds while it is full.
// ----------------------------------------------------------------------------
module page_allocator_with_refcount_unit
	import parc_pkg::*;
#(
	parameter int unsigned PAGE_COUNT = 2048,
	parameter int unsigned PAGE_SHIFT = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	parc_req_if.sink          req,
	parc_rsp_if.source        rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int unsigned IDX_W = $clog2(PAGE_COUNT);
	localparam int unsigned DEP_W = $clog2(PAGE_COUNT + 1);

	// configuration
	logic [39:0] mem_base_q, mem_top_q, reserved_end_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_base_q     <= MEM_BASE_RST;
			mem_top_q      <= MEM_TOP_RST;
			reserved_end_q <= RESERVED_END_RST;
		end else if (cfg_wr) begin
			unique case (paddr[4:3])
				REG_MEM_BASE:     mem_base_q     <= pwdata[39:0];
				REG_MEM_TOP:      mem_top_q      <= pwdata[39:0];
				REG_RESERVED_END: reserved_end_q <= pwdata[39:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			REG_MEM_BASE:     prdata = APB_DW'(mem_base_q);
			REG_MEM_TOP:      prdata = APB_DW'(mem_top_q);
			REG_RESERVED_END: prdata = APB_DW'(reserved_end_q);
			default:          prdata = '0;
		endcase
	end

	// control
	state_t             state_q, state_d;
	logic [IDX_W-1:0]   clr_q;
	logic [DEP_W-1:0]   depth_q, depth_d;
	logic               res_valid_q;
	logic               accept, commit;

	// request decode in the transfer cycle
	logic [40:0]        diff;
	logic [39:0]        off;
	logic               in_range, free_bad;

	assign diff     = {1'b0, req.page_addr} - {1'b0, mem_base_q};
	assign off      = diff[39:0] >> PAGE_SHIFT;
	assign in_range = !diff[40] && ({1'b0, off} < 41'(PAGE_COUNT));
	assign free_bad = (|req.page_addr[PAGE_SHIFT-1:0]) || (req.page_addr < reserved_end_q)
		|| (req.page_addr >= mem_top_q) || !in_range;

	logic [2:0]         func_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               ok_s1, bad_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= req.func;
			idx_s1  <= off[IDX_W-1:0];
			ok_s1   <= in_range;
			bad_s1  <= free_bad;
		end
	end

	// memories
	logic [7:0]       cnt_mem [PAGE_COUNT];
	logic [IDX_W-1:0] stk_mem [PAGE_COUNT];
	logic [7:0]       cnt_rdata_q;
	logic [IDX_W-1:0] stk_rdata_q;
	logic             cnt_we, stk_we, x_cnt_we, x_stk_we;
	logic [IDX_W-1:0] cnt_waddr, x_cnt_waddr, stk_waddr;
	logic [7:0]       cnt_wdata, x_cnt_wdata;
	logic [DEP_W-1:0] depth_m1;

	assign depth_m1 = depth_q - DEP_W'(1);

	always_ff @(posedge clk) begin
		if (cnt_we)
			cnt_mem[cnt_waddr] <= cnt_wdata;
		if (accept)
			cnt_rdata_q <= cnt_mem[off[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (stk_we)
			stk_mem[stk_waddr] <= idx_s1;
		if (accept)
			stk_rdata_q <= stk_mem[depth_m1[IDX_W-1:0]];
	end

	// modify
	logic [2:0]  x_status;
	logic [39:0] x_aaddr;
	logic [7:0]  x_refv, cnt_dec, cnt_inc;

	assign cnt_dec   = (cnt_rdata_q == 8'd0) ? 8'd0 : cnt_rdata_q - 8'd1;
	assign cnt_inc   = (cnt_rdata_q == REF_MAX) ? REF_MAX : cnt_rdata_q + 8'd1;
	assign stk_waddr = depth_q[IDX_W-1:0];

	always_comb begin
		x_status    = STATUS_OK;
		x_aaddr     = '0;
		x_refv      = '0;
		depth_d     = depth_q;
		x_cnt_we    = 1'b0;
		x_cnt_waddr = idx_s1;
		x_cnt_wdata = cnt_dec;
		x_stk_we    = 1'b0;
		unique case (func_s1)
			FUNC_ALLOC: begin
				if (depth_q == '0) begin
					x_status = STATUS_NO_FREE;
				end else begin
					depth_d     = depth_m1;
					x_cnt_we    = 1'b1;
					x_cnt_waddr = stk_rdata_q;
					x_cnt_wdata = 8'd1;
					x_aaddr     = mem_base_q + (40'(stk_rdata_q) << PAGE_SHIFT);
					x_refv      = 8'd1;
				end
			end
			FUNC_FREE: begin
				if (bad_s1) begin
					x_status = STATUS_BAD_FREE;
				end else begin
					x_cnt_we = 1'b1;
					if (cnt_dec != 8'd0) begin
						x_status = STATUS_STILL_REF;
						x_refv   = cnt_dec;
					end else if (depth_q == DEP_W'(PAGE_COUNT)) begin
						x_status = STATUS_OVERFLOW;
					end else begin
						x_stk_we = 1'b1;
						depth_d  = depth_q + DEP_W'(1);
					end
				end
			end
			FUNC_INCREF: begin
				if (ok_s1) begin
					x_cnt_we    = 1'b1;
					x_cnt_wdata = cnt_inc;
					x_refv      = cnt_inc;
				end
			end
			FUNC_DECREF: begin
				if (ok_s1) begin
					x_cnt_we = 1'b1;
					x_refv   = cnt_dec;
				end
			end
			FUNC_GETREF: begin
				if (ok_s1)
					x_refv = cnt_rdata_q;
			end
			default: ;
		endcase
	end

	// sequencing
	always_comb begin
		state_d   = state_q;
		accept    = 1'b0;
		commit    = 1'b0;
		req.ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == IDX_W'(PAGE_COUNT - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				req.ready = 1'b1;
				accept    = req.valid;
				if (req.valid)
					state_d = ST_EXEC;
			end
			ST_EXEC: begin
				commit = !res_valid_q || rsp.ready;
				if (commit)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		if (state_q == ST_CLEAR) begin
			cnt_we    = 1'b1;
			cnt_waddr = clr_q;
			cnt_wdata = '0;
		end else begin
			cnt_we    = commit && x_cnt_we;
			cnt_waddr = x_cnt_waddr;
			cnt_wdata = x_cnt_wdata;
		end
		stk_we = commit && x_stk_we;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			depth_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + IDX_W'(1);
			if (commit) begin
				depth_q     <= depth_d;
				res_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// response register
	logic [63:0] depth_w;

	assign depth_w = 64'(depth_d);

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp.status     <= x_status;
			rsp.alloc_addr <= x_aaddr;
			rsp.ref_value  <= x_refv;
			rsp.free_pages <= depth_w[11:0];
			rsp.free_bytes <= 24'(depth_w << PAGE_SHIFT);
		end
	end

	assign rsp.valid = res_valid_q;

endmodule
